// ===== hdl/pps_pkg.sv =====
package pps_pkg;

    localparam int MAX_SLOTS     = 16;
    localparam int SLOT_BITS     = $clog2(MAX_SLOTS);
    localparam int IDX_BITS      = SLOT_BITS + 1;
    localparam int ARR_BITS      = 16;
    localparam int BURST_BITS    = 12;
    localparam int PRIORITY_BITS = 8;
    localparam int TIME_BITS     = 17;
    localparam int COUNT_BITS    = 5;
    localparam int FUNC_BITS     = 2;
    localparam int PAR_BITS      = ARR_BITS + BURST_BITS + PRIORITY_BITS;

    localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [FUNC_BITS-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_TICK    = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_RESTART = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                     rd_en;
        logic [SLOT_BITS-1:0]     rd_addr;
        logic [SLOT_BITS-1:0]     wr_addr;
        logic                     par_we;
        logic [ARR_BITS-1:0]      par_arr;
        logic [BURST_BITS-1:0]    par_burst;
        logic [PRIORITY_BITS-1:0] par_prio;
        logic                     rem_we;
        logic [BURST_BITS-1:0]    rem_wdata;
    } t_mem_req;

    typedef struct packed {
        logic [ARR_BITS-1:0]      arr;
        logic [BURST_BITS-1:0]    burst;
        logic [PRIORITY_BITS-1:0] prio;
        logic [BURST_BITS-1:0]    rem;
    } t_mem_rsp;

    typedef struct packed {
        logic                 ran_valid;
        logic [SLOT_BITS-1:0] ran_slot;
        logic                 finished;
        logic [TIME_BITS-1:0] comp;
        logic [TIME_BITS-1:0] wait_t;
        logic [TIME_BITS-1:0] turn;
        logic                 all_done;
    } t_result;

endpackage

// ===== hdl/pps_table.sv =====
module pps_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pps_pkg::t_mem_req i_req,
    output pps_pkg::t_mem_rsp o_rsp
);

    logic [pps_pkg::PAR_BITS-1:0]   r_par_mem [pps_pkg::MAX_SLOTS];
    logic [pps_pkg::BURST_BITS-1:0] r_rem_mem [pps_pkg::MAX_SLOTS];
    logic [pps_pkg::MAX_SLOTS-1:0]  r_rem_vld;

    logic [pps_pkg::PAR_BITS-1:0]   r_par_q;
    logic [pps_pkg::BURST_BITS-1:0] r_rem_q;
    logic                           r_rem_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.par_we) begin
            r_par_mem[i_req.wr_addr] <= {i_req.par_arr, i_req.par_burst, i_req.par_prio};
        end
        if (i_req.rem_we) begin
            r_rem_mem[i_req.wr_addr] <= i_req.rem_wdata;
        end
        if (i_req.rd_en) begin
            r_par_q <= r_par_mem[i_req.rd_addr];
            r_rem_q <= r_rem_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_vld   <= '0;
            r_rem_q_vld <= 1'b0;
        end else begin
            if (i_req.rem_we) begin
                r_rem_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rem_q_vld <= r_rem_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rsp.arr   = r_par_q[pps_pkg::PAR_BITS-1 -: pps_pkg::ARR_BITS];
    assign o_rsp.burst = r_par_q[pps_pkg::PRIORITY_BITS +: pps_pkg::BURST_BITS];
    assign o_rsp.prio  = r_par_q[pps_pkg::PRIORITY_BITS-1:0];
    assign o_rsp.rem   = r_rem_q_vld ? r_rem_q : '0;

endmodule

// ===== hdl/pps_ctrl.sv =====
module pps_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pps_pkg::FUNC_BITS-1:0]     i_func,
    input  logic [pps_pkg::SLOT_BITS-1:0]     i_slot,
    input  logic [pps_pkg::ARR_BITS-1:0]      i_arrival_time,
    input  logic [pps_pkg::BURST_BITS-1:0]    i_burst_length,
    input  logic [pps_pkg::PRIORITY_BITS-1:0] i_priority_req,
    input  logic [pps_pkg::IDX_BITS-1:0]      i_eff_count,
    output pps_pkg::t_mem_req                 o_req,
    input  pps_pkg::t_mem_rsp                 i_rsp,
    input  logic                              i_out_free,
    output logic                              o_res_push,
    output pps_pkg::t_result                  o_res
);

    pps_pkg::t_state r_state, n_state;

    logic [pps_pkg::FUNC_BITS-1:0]     r_func;
    logic [pps_pkg::IDX_BITS-1:0]      r_idx;
    logic                              r_dvld;
    logic [pps_pkg::SLOT_BITS-1:0]     r_daddr;
    logic                              r_found;
    logic [pps_pkg::SLOT_BITS-1:0]     r_best_slot;
    logic [pps_pkg::PRIORITY_BITS-1:0] r_best_prio;
    logic [pps_pkg::ARR_BITS-1:0]      r_best_arr;
    logic [pps_pkg::BURST_BITS-1:0]    r_best_burst;
    logic [pps_pkg::BURST_BITS-1:0]    r_best_rem;
    logic [pps_pkg::TIME_BITS-1:0]     r_time;
    logic [pps_pkg::COUNT_BITS-1:0]    r_count;

    logic                              r_ran_valid;
    logic [pps_pkg::SLOT_BITS-1:0]     r_ran_slot;
    logic                              r_finished;
    logic [pps_pkg::TIME_BITS-1:0]     r_comp;
    logic [pps_pkg::TIME_BITS-1:0]     r_turn;

    logic                              accept;
    logic                              issue;
    logic                              scan_end;
    logic                              cand;
    logic [pps_pkg::TIME_BITS-1:0]     end_time;
    logic [pps_pkg::TIME_BITS-1:0]     arr_ext;
    logic [pps_pkg::TIME_BITS-1:0]     burst_ext;

    assign accept   = i_valid && (r_state == pps_pkg::S_IDLE);
    assign issue    = (r_state == pps_pkg::S_SCAN)
                      && (r_idx < pps_pkg::IDX_BITS'(pps_pkg::MAX_SLOTS));
    assign scan_end = (r_state == pps_pkg::S_SCAN) && !issue && !r_dvld;

    assign cand = r_dvld && (r_func == pps_pkg::FUNC_TICK)
                  && ({1'b0, r_daddr} < i_eff_count)
                  && (pps_pkg::TIME_BITS'(i_rsp.arr) <= r_time)
                  && (i_rsp.rem != '0);

    assign end_time  = (r_time == pps_pkg::TIME_MAX) ? pps_pkg::TIME_MAX
                                                     : r_time + 1'b1;
    assign arr_ext   = pps_pkg::TIME_BITS'(r_best_arr);
    assign burst_ext = pps_pkg::TIME_BITS'(r_best_burst);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pps_pkg::S_IDLE: begin
                if (accept) begin
                    if ((i_func == pps_pkg::FUNC_TICK) || (i_func == pps_pkg::FUNC_RESTART)) begin
                        n_state = pps_pkg::S_SCAN;
                    end else begin
                        n_state = pps_pkg::S_DONE;
                    end
                end
            end
            pps_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = (r_func == pps_pkg::FUNC_TICK) ? pps_pkg::S_UPDATE
                                                             : pps_pkg::S_DONE;
                end
            end
            pps_pkg::S_UPDATE: begin
                n_state = pps_pkg::S_DONE;
            end
            pps_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = pps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pps_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready         = (r_state == pps_pkg::S_IDLE);
        o_res_push      = (r_state == pps_pkg::S_DONE) && i_out_free;
        o_req           = '0;
        o_req.rd_en     = issue;
        o_req.rd_addr   = r_idx[pps_pkg::SLOT_BITS-1:0];
        unique case (r_state)
            pps_pkg::S_IDLE: begin
                if (accept && (i_func == pps_pkg::FUNC_LOAD)) begin
                    o_req.par_we    = 1'b1;
                    o_req.rem_we    = 1'b1;
                    o_req.wr_addr   = i_slot;
                    o_req.par_arr   = i_arrival_time;
                    o_req.par_burst = i_burst_length;
                    o_req.par_prio  = i_priority_req;
                    o_req.rem_wdata = i_burst_length;
                end
            end
            pps_pkg::S_SCAN: begin
                if (r_dvld && (r_func == pps_pkg::FUNC_RESTART)) begin
                    o_req.rem_we    = 1'b1;
                    o_req.wr_addr   = r_daddr;
                    o_req.rem_wdata = i_rsp.burst;
                end
            end
            pps_pkg::S_UPDATE: begin
                if (r_found) begin
                    o_req.rem_we    = 1'b1;
                    o_req.wr_addr   = r_best_slot;
                    o_req.rem_wdata = r_best_rem - 1'b1;
                end
            end
            pps_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.ran_valid = r_ran_valid;
        o_res.ran_slot  = r_ran_slot;
        o_res.finished  = r_finished;
        o_res.comp      = r_comp;
        o_res.turn      = r_turn;
        o_res.wait_t    = (r_turn > burst_ext) ? r_turn - burst_ext : '0;
        o_res.all_done  = (pps_pkg::IDX_BITS'(r_count) == i_eff_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pps_pkg::S_IDLE;
            r_idx   <= '0;
            r_dvld  <= 1'b0;
            r_found <= 1'b0;
            r_time  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_dvld  <= issue;
            if (accept) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (cand && (!r_found || (i_rsp.prio > r_best_prio))) begin
                r_found <= 1'b1;
            end
            if (scan_end && (r_func == pps_pkg::FUNC_RESTART)) begin
                r_time  <= '0;
                r_count <= '0;
            end
            if (r_state == pps_pkg::S_UPDATE) begin
                if (r_time != pps_pkg::TIME_MAX) begin
                    r_time <= r_time + 1'b1;
                end
                if (r_found && (r_best_rem == pps_pkg::BURST_BITS'(1))
                    && (r_count != pps_pkg::COUNT_MAX)) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_daddr <= r_idx[pps_pkg::SLOT_BITS-1:0];
        if (accept) begin
            r_func      <= i_func;
            r_ran_valid <= 1'b0;
            r_ran_slot  <= '0;
            r_finished  <= 1'b0;
            r_comp      <= '0;
            r_turn      <= '0;
            r_best_burst <= '0;
        end
        if (cand && (!r_found || (i_rsp.prio > r_best_prio))) begin
            r_best_slot  <= r_daddr;
            r_best_prio  <= i_rsp.prio;
            r_best_arr   <= i_rsp.arr;
            r_best_burst <= i_rsp.burst;
            r_best_rem   <= i_rsp.rem;
        end
        if ((r_state == pps_pkg::S_UPDATE) && r_found) begin
            r_ran_valid <= 1'b1;
            r_ran_slot  <= r_best_slot;
            if (r_best_rem == pps_pkg::BURST_BITS'(1)) begin
                r_finished <= 1'b1;
                r_comp     <= end_time;
                r_turn     <= (end_time > arr_ext) ? end_time - arr_ext : '0;
            end else begin
                r_best_burst <= '0;
            end
        end else if (r_state == pps_pkg::S_UPDATE) begin
            r_best_burst <= '0;
        end
    end

endmodule

// ===== hdl/preemptive_priority_scheduler.sv =====
// Tick-driven preemptive priority scheduler over a 16-slot process table held in
// two synchronous memories (slot parameters, remaining work), each with one read
// port and one write port. A load or unused item is accepted and then handed off
// to the output register. A tick item and a restart item are both accepted, then
// sweep the table one slot per cycle through the read port; a further step covers
// the read latency and another closes the sweep. A tick then writes back the
// chosen slot's remaining work. Both end by handing the result to the output
// register. That handoff waits while the output register still holds a result that
// has not been accepted. One result item comes out for every input item, in order.
// process_count is written through i_cfg_wen / i_cfg_wdata; the user must write it
// only while the block is idle, as the block does not enforce this. Values above
// 16 act as 16.
module preemptive_priority_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [pps_pkg::COUNT_BITS-1:0]    i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pps_pkg::FUNC_BITS-1:0]     i_func,
    input  logic [pps_pkg::SLOT_BITS-1:0]     i_slot,
    input  logic [pps_pkg::ARR_BITS-1:0]      i_arrival_time,
    input  logic [pps_pkg::BURST_BITS-1:0]    i_burst_length,
    input  logic [pps_pkg::PRIORITY_BITS-1:0] i_priority_req,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_ran_valid,
    output logic [pps_pkg::SLOT_BITS-1:0]     o_ran_slot,
    output logic                              o_finished,
    output logic [pps_pkg::TIME_BITS-1:0]     o_completion_time,
    output logic [pps_pkg::TIME_BITS-1:0]     o_waiting_time,
    output logic [pps_pkg::TIME_BITS-1:0]     o_turnaround_time,
    output logic                              o_all_done
);

    logic [pps_pkg::COUNT_BITS-1:0] r_proc_count;
    logic [pps_pkg::IDX_BITS-1:0]   eff_count;
    logic                           r_o_valid;
    pps_pkg::t_result               r_res;
    pps_pkg::t_result               res;
    pps_pkg::t_mem_req              req;
    pps_pkg::t_mem_rsp              rsp;
    logic                           res_push;
    logic                           out_free;

    assign eff_count = (pps_pkg::IDX_BITS'(r_proc_count) > pps_pkg::IDX_BITS'(pps_pkg::MAX_SLOTS))
                       ? pps_pkg::IDX_BITS'(pps_pkg::MAX_SLOTS)
                       : pps_pkg::IDX_BITS'(r_proc_count);
    assign out_free  = !r_o_valid || i_ready;

    pps_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    pps_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .i_arrival_time (i_arrival_time),
        .i_burst_length (i_burst_length),
        .i_priority_req (i_priority_req),
        .i_eff_count    (eff_count),
        .o_req          (req),
        .i_rsp          (rsp),
        .i_out_free     (out_free),
        .o_res_push     (res_push),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_count <= pps_pkg::COUNT_BITS'(1);
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_proc_count <= i_cfg_wdata;
            end
            if (res_push) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res <= res;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_ran_valid       = r_res.ran_valid;
    assign o_ran_slot        = r_res.ran_slot;
    assign o_finished        = r_res.finished;
    assign o_completion_time = r_res.comp;
    assign o_waiting_time    = r_res.wait_t;
    assign o_turnaround_time = r_res.turn;
    assign o_all_done        = r_res.all_done;

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> out_free)
        else $error("result pushed into a full output register");

    a_idle_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !res_push)
        else $error("result pushed while no item is in flight");

    a_finish_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> o_ran_valid)
        else $error("completion reported on a tick with no running slot");

    a_time_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |->
            (o_waiting_time <= o_turnaround_time) && (o_turnaround_time <= o_completion_time))
        else $error("waiting, turnaround and completion times out of order");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pps_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 68;

    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

    class sched_tracker;
        logic [ARR_BITS-1:0]      arrival_tab [MAX_SLOTS];
        logic [BURST_BITS-1:0]    burst_tab   [MAX_SLOTS];
        logic [BURST_BITS-1:0]    left_tab    [MAX_SLOTS];
        logic [PRIORITY_BITS-1:0] prio_tab    [MAX_SLOTS];
        logic [TIME_BITS-1:0]     now_tick;
        logic [COUNT_BITS-1:0]    done_count;
        logic [COUNT_BITS-1:0]    proc_count;
        t_result                  due_results [$];
        int                       errors;

        function new();
            foreach (left_tab[i]) left_tab[i] = '0;
            now_tick   = '0;
            done_count = '0;
            proc_count = COUNT_BITS'(1);
            errors     = 0;
        endfunction

        function int active_slots();
            return (proc_count > MAX_SLOTS) ? MAX_SLOTS : int'(proc_count);
        endfunction

        function void set_count(logic [COUNT_BITS-1:0] value);
            proc_count = value;
        endfunction

        function void note_item(logic [FUNC_BITS-1:0] func, logic [SLOT_BITS-1:0] slot,
                                logic [ARR_BITS-1:0] arr, logic [BURST_BITS-1:0] burst,
                                logic [PRIORITY_BITS-1:0] prio);
            t_result r;
            int      best;
            int      end_tick;
            int      span;
            r    = '0;
            best = -1;
            case (func)
                FUNC_LOAD: begin
                    arrival_tab[slot] = arr;
                    burst_tab[slot]   = burst;
                    prio_tab[slot]    = prio;
                    left_tab[slot]    = burst;
                end
                FUNC_RESTART: begin
                    foreach (left_tab[i]) left_tab[i] = burst_tab[i];
                    now_tick   = '0;
                    done_count = '0;
                end
                FUNC_TICK: begin
                    for (int i = 0; i < active_slots(); i++) begin
                        if (arrival_tab[i] <= now_tick && left_tab[i] != 0 &&
                            (best < 0 || prio_tab[i] > prio_tab[best]))
                            best = i;
                    end
                    if (best >= 0) begin
                        r.ran_valid = 1'b1;
                        r.ran_slot  = best[SLOT_BITS-1:0];
                        left_tab[best]--;
                        if (left_tab[best] == 0) begin
                            end_tick = int'(now_tick) + 1;
                            if (end_tick > int'(TIME_MAX)) end_tick = int'(TIME_MAX);
                            span = (end_tick > int'(arrival_tab[best])) ?
                                   end_tick - int'(arrival_tab[best]) : 0;
                            r.finished = 1'b1;
                            r.comp     = end_tick[TIME_BITS-1:0];
                            r.turn     = span[TIME_BITS-1:0];
                            span       = (span > int'(burst_tab[best])) ?
                                         span - int'(burst_tab[best]) : 0;
                            r.wait_t   = span[TIME_BITS-1:0];
                            if (done_count != COUNT_MAX) done_count++;
                        end
                    end
                    if (now_tick != TIME_MAX) now_tick++;
                end
                default: ;
            endcase
            r.all_done = (int'(done_count) == active_slots());
            due_results.push_back(r);
        endfunction

        function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
            if (a !== e) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (due_results.size() == 0) begin
                $error("result item arrived with no item outstanding");
                errors++;
                return;
            end
            e = due_results.pop_front();
            cmp_field("ran_valid", 32'(e.ran_valid), 32'(got.ran_valid));
            cmp_field("ran_slot", 32'(e.ran_slot), 32'(got.ran_slot));
            cmp_field("finished", 32'(e.finished), 32'(got.finished));
            cmp_field("completion_time", 32'(e.comp), 32'(got.comp));
            cmp_field("waiting_time", 32'(e.wait_t), 32'(got.wait_t));
            cmp_field("turnaround_time", 32'(e.turn), 32'(got.turn));
            cmp_field("all_done", 32'(e.all_done), 32'(got.all_done));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wen;
    logic [COUNT_BITS-1:0] i_cfg_wdata;
    logic i_valid;
    logic o_ready;
    logic [FUNC_BITS-1:0] i_func;
    logic [SLOT_BITS-1:0] i_slot;
    logic [ARR_BITS-1:0] i_arrival_time;
    logic [BURST_BITS-1:0] i_burst_length;
    logic [PRIORITY_BITS-1:0] i_priority_req;
    logic o_valid;
    logic i_ready;
    logic o_ran_valid;
    logic [SLOT_BITS-1:0] o_ran_slot;
    logic o_finished;
    logic [TIME_BITS-1:0] o_completion_time;
    logic [TIME_BITS-1:0] o_waiting_time;
    logic [TIME_BITS-1:0] o_turnaround_time;
    logic o_all_done;

    sched_tracker tracker;
    bit steady;
    bit hold_request;
    int idle_cycles;
    int stall_left;

    preemptive_priority_scheduler dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wen         (i_cfg_wen),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_slot            (i_slot),
        .i_arrival_time    (i_arrival_time),
        .i_burst_length    (i_burst_length),
        .i_priority_req    (i_priority_req),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_ran_valid       (o_ran_valid),
        .o_ran_slot        (o_ran_slot),
        .o_finished        (o_finished),
        .o_completion_time (o_completion_time),
        .o_waiting_time    (o_waiting_time),
        .o_turnaround_time (o_turnaround_time),
        .o_all_done        (o_all_done)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic send_item(logic [FUNC_BITS-1:0] func, logic [SLOT_BITS-1:0] slot,
                             logic [ARR_BITS-1:0] arr, logic [BURST_BITS-1:0] burst,
                             logic [PRIORITY_BITS-1:0] prio);
        int gap;
        gap = 0;
        if (!steady) begin
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(10, 40);
            else if ($urandom_range(0, 1) == 0)
                gap = $urandom_range(1, 3);
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid        = 1'b1;
        i_func         = func;
        i_slot         = slot;
        i_arrival_time = arr;
        i_burst_length = burst;
        i_priority_req = prio;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.note_item(func, slot, arr, burst, prio);
    endtask

    task automatic send_filler(logic [FUNC_BITS-1:0] func);
        send_item(func, SLOT_BITS'($urandom), ARR_BITS'($urandom), BURST_BITS'($urandom),
                  PRIORITY_BITS'($urandom));
    endtask

    task automatic idle_until_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_count(logic [COUNT_BITS-1:0] value);
        idle_until_drained();
        @(negedge i_clk);
        i_cfg_wen   = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_wen = 1'b0;
        tracker.set_count(value);
    endtask

    task automatic random_item();
        int pick;
        int base;
        logic [FUNC_BITS-1:0] func;
        logic [ARR_BITS-1:0] arr;
        logic [BURST_BITS-1:0] burst;
        logic [PRIORITY_BITS-1:0] prio;
        pick  = $urandom_range(0, 99);
        func  = (pick < 50) ? FUNC_TICK : (pick < 88) ? FUNC_LOAD :
                (pick < 94) ? FUNC_RESTART : FUNC_UNUSED;
        arr   = ARR_BITS'($urandom);
        burst = BURST_BITS'($urandom);
        prio  = PRIORITY_BITS'($urandom);
        if (func == FUNC_LOAD && $urandom_range(0, 9) != 0) begin
            base = int'(tracker.now_tick);
            if ($urandom_range(0, 2) == 0)
                base = $urandom_range(0, base);
            else
                base = base + $urandom_range(0, 12);
            if (base > 65535) base = 65535;
            arr   = base[ARR_BITS-1:0];
            burst = ($urandom_range(0, 9) == 0) ? '0 : BURST_BITS'($urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0) prio = PRIORITY_BITS'($urandom_range(0, 3));
        end
        send_item(func, SLOT_BITS'($urandom_range(0, MAX_SLOTS - 1)), arr, burst, prio);
    endtask

    initial begin
        i_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else begin
                i_ready = 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
                                                               $urandom_range(1, 3);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_result({o_ran_valid, o_ran_slot, o_finished, o_completion_time,
                                  o_waiting_time, o_turnaround_time, o_all_done});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int count_plan [PHASES];
        tracker        = new();
        count_plan     = '{1, 0, 31, 16, 17, 5, 2, 16, 9, 12};
        steady         = 1'b0;
        hold_request   = 1'b0;
        idle_cycles    = 0;
        i_rst_n        = 1'b0;
        i_cfg_wen      = 1'b0;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_func         = FUNC_LOAD;
        i_slot         = '0;
        i_arrival_time = '0;
        i_burst_length = '0;
        i_priority_req = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_count(COUNT_BITS'(16));
        for (int s = 0; s < MAX_SLOTS; s++)
            send_item(FUNC_LOAD, SLOT_BITS'(s), ARR_BITS'(s / 4), BURST_BITS'((s % 3) + 1),
                      PRIORITY_BITS'((s / 2) * 34));
        send_item(FUNC_LOAD, SLOT_BITS'(13), 16'h0000, 12'h000, 8'd200);
        send_item(FUNC_LOAD, SLOT_BITS'(14), 16'hFFFF, 12'hFFF, 8'hFF);
        repeat (4) send_filler(FUNC_TICK);
        send_filler(FUNC_UNUSED);
        send_filler(FUNC_RESTART);
        repeat (2) send_filler(FUNC_TICK);

        for (int p = 0; p < PHASES; p++) begin
            write_count(COUNT_BITS'((p < 7) ? count_plan[p] : $urandom_range(0, 31)));
            steady = (p == 6);
            if (p == 3) hold_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 59) == 0) idle_until_drained();
                random_item();
            end
        end
        steady = 1'b0;

        idle_until_drained();
        repeat (40) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.due_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
